@@ rtl/core/owm_pkg.sv @@
// Shared types, constants and lookup functions of the 1-Wire temperature master.
// No dependencies; every module file of the block imports this package.
package owm_pkg;

    // Bus timer width and its largest value.
    localparam int TIMER_BITS = 10;
    localparam int TMAX       = (1 << TIMER_BITS) - 1;

    // Field widths of the channels.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int TENTHS_W   = 13;

    // Bits in one bus byte and the last step of the temperature sequence.
    localparam int BITS_PER_BYTE = 8;
    localparam int SEQ_LAST      = 7;
    localparam int SEQ_LOW_BYTE  = 6;

    // Saturation limit of the converted temperature.
    localparam int TENTHS_MAX = 2048;

    // Depth of the queue between controller and output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Register reset values.
    localparam logic [9:0] RST_LOW_DEF    = 10'd750;
    localparam logic [7:0] RST_REL_DEF    = 8'd15;
    localparam logic [9:0] PRES_WAIT_DEF  = 10'd200;
    localparam logic [9:0] PRES_LOW_DEF   = 10'd240;
    localparam logic [5:0] WR1_LOW_DEF    = 6'd5;
    localparam logic [7:0] SLOT_LONG_DEF  = 8'd60;
    localparam logic [5:0] RD_SAMPLE_DEF  = 6'd10;
    localparam logic [7:0] RD_REC_DEF     = 8'd50;

    // ROM and function commands of the sensor.
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RST_LOW   = 3'd0,
        CFG_RST_REL   = 3'd1,
        CFG_PRES_WAIT = 3'd2,
        CFG_PRES_LOW  = 3'd3,
        CFG_WR1_LOW   = 3'd4,
        CFG_SLOT_LONG = 3'd5,
        CFG_RD_SAMPLE = 3'd6,
        CFG_RD_REC    = 3'd7
    } t_cfg_idx;

    // Requested operation.
    typedef enum logic [1:0] {
        FN_RESET = 2'd0,
        FN_WRITE = 2'd1,
        FN_READ  = 2'd2,
        FN_TEMP  = 2'd3
    } t_func;

    // Primitive bus operation.
    typedef enum logic [1:0] {
        OP_RST = 2'd0,
        OP_WR  = 2'd1,
        OP_RD  = 2'd2
    } t_op;

    // Controller phase.
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_RST_LOW   = 5'd1,
        PH_RST_REL   = 5'd2,
        PH_PRES_WAIT = 5'd3,
        PH_PRES_LOW  = 5'd4,
        PH_WR_LOW    = 5'd5,
        PH_WR_HIGH   = 5'd6,
        PH_RD_LOW    = 5'd7,
        PH_RD_WAIT   = 5'd8,
        PH_RD_REC    = 5'd9,
        PH_FINISH    = 5'd10
    } t_phase;

    // One tick's result as it travels through the queue.
    typedef struct packed {
        logic              drive;
        logic              busy;
        logic              done;
        logic              fail;
        logic [BYTE_W-1:0] rx;
        logic [RAW_W-1:0]  raw;
    } t_res;

    // Operation of each step of the temperature sequence.
    function automatic t_op seq_kind(input logic [2:0] step);
        case (step)
            3'd0:    seq_kind = OP_RST;
            3'd1:    seq_kind = OP_WR;
            3'd2:    seq_kind = OP_WR;
            3'd3:    seq_kind = OP_RST;
            3'd4:    seq_kind = OP_WR;
            3'd5:    seq_kind = OP_WR;
            default: seq_kind = OP_RD;
        endcase
    endfunction

    // Byte sent by each step of the temperature sequence.
    function automatic logic [7:0] seq_byte(input logic [2:0] step);
        case (step)
            3'd1:    seq_byte = CMD_SKIP_ROM;
            3'd2:    seq_byte = CMD_CONVERT;
            3'd4:    seq_byte = CMD_SKIP_ROM;
            3'd5:    seq_byte = CMD_READ_SP;
            default: seq_byte = 8'h00;
        endcase
    endfunction

    // First phase of a bus operation.
    function automatic t_phase begin_phase(input t_op kind);
        case (kind)
            OP_RST:  begin_phase = PH_RST_LOW;
            OP_WR:   begin_phase = PH_WR_LOW;
            default: begin_phase = PH_RD_LOW;
        endcase
    endfunction

    // Timing register as a timer limit: zero counts as one, large values clamp.
    function automatic logic [TIMER_BITS-1:0] lim(input logic [15:0] v);
        if (v == 16'd0) begin
            lim = TIMER_BITS'(1);
        end else if (v > 16'(TMAX)) begin
            lim = TIMER_BITS'(TMAX);
        end else begin
            lim = v[TIMER_BITS-1:0];
        end
    endfunction

endpackage

@@ rtl/core/owm_if.sv @@
// Valid/ready channel interfaces of the 1-Wire temperature master.
// No dependencies; the field widths are literals that match owm_pkg.
interface owm_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       dq_sample;

    modport source (output valid, start_req, func, tx_byte, dq_sample, input ready);
    modport sink   (input valid, start_req, func, tx_byte, dq_sample, output ready);
endinterface

interface owm_out_if;
    logic               valid;
    logic               ready;
    logic               dq_drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_fail;
    logic [7:0]         rx_byte;
    logic signed [15:0] raw_temp;
    logic signed [12:0] temp_tenths;

    modport source (output valid, dq_drive_low, busy_res, done_res, presence_fail,
                    rx_byte, raw_temp, temp_tenths, input ready);
    modport sink   (input valid, dq_drive_low, busy_res, done_res, presence_fail,
                    rx_byte, raw_temp, temp_tenths, output ready);
endinterface

interface owm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/owm_ctrl.sv @@
// Front part: timing registers and the bus sequencer, one tick item per cycle while the queue is not full.
// Depends on owm_pkg and the channel interfaces in owm_if.sv.
module owm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    owm_in_if.sink        i_in,
    owm_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output owm_pkg::t_res o_res
);
    import owm_pkg::*;

    // Timing registers.
    logic [9:0] r_rst_low, r_pres_wait, r_pres_low;
    logic [7:0] r_rst_rel, r_slot_long, r_rd_rec;
    logic [5:0] r_wr1_low, r_rd_sample;

    // Sequencer state.
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [3:0]            r_bits, n_bits;
    logic [7:0]            r_shift, n_shift;
    logic [2:0]            r_step, n_step;
    logic [7:0]            r_low, n_low;
    logic                  r_fail, n_fail;
    logic [15:0]           r_word, n_word;
    t_func                 r_func, n_func;
    logic [7:0]            r_rx, n_rx;

    logic                  acc;
    logic                  drive, busy, done, op_end;
    logic [TIMER_BITS-1:0] timer_inc, len;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_in.valid && i_in.ready;
    assign timer_inc   = r_timer + TIMER_BITS'(1);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_low   <= RST_LOW_DEF;
            r_rst_rel   <= RST_REL_DEF;
            r_pres_wait <= PRES_WAIT_DEF;
            r_pres_low  <= PRES_LOW_DEF;
            r_wr1_low   <= WR1_LOW_DEF;
            r_slot_long <= SLOT_LONG_DEF;
            r_rd_sample <= RD_SAMPLE_DEF;
            r_rd_rec    <= RD_REC_DEF;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_RST_LOW:   r_rst_low   <= i_cfg.data;
                CFG_RST_REL:   r_rst_rel   <= i_cfg.data[7:0];
                CFG_PRES_WAIT: r_pres_wait <= i_cfg.data;
                CFG_PRES_LOW:  r_pres_low  <= i_cfg.data;
                CFG_WR1_LOW:   r_wr1_low   <= i_cfg.data[5:0];
                CFG_SLOT_LONG: r_slot_long <= i_cfg.data[7:0];
                CFG_RD_SAMPLE: r_rd_sample <= i_cfg.data[5:0];
                CFG_RD_REC:    r_rd_rec    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_step  <= '0;
            r_low   <= '0;
            r_fail  <= 1'b1;
            r_word  <= '0;
            r_func  <= FN_RESET;
            r_rx    <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_step  <= n_step;
            r_low   <= n_low;
            r_fail  <= n_fail;
            r_word  <= n_word;
            r_func  <= n_func;
            r_rx    <= n_rx;
        end
    end

    // Next state and the tick's bus outputs.
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_step  = r_step;
        n_low   = r_low;
        n_fail  = r_fail;
        n_word  = r_word;
        n_func  = r_func;
        n_rx    = r_rx;
        drive   = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        op_end  = 1'b0;
        len     = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_in.start_req) begin
                    busy    = 1'b1;
                    n_func  = t_func'(i_in.func);
                    n_step  = '0;
                    n_timer = '0;
                    n_bits  = '0;
                    case (t_func'(i_in.func))
                        FN_RESET: begin
                            n_phase = PH_RST_LOW;
                            n_shift = 8'h00;
                        end
                        FN_WRITE: begin
                            n_phase = PH_WR_LOW;
                            n_shift = i_in.tx_byte;
                        end
                        FN_READ: begin
                            n_phase = PH_RD_LOW;
                            n_shift = 8'h00;
                        end
                        default: begin
                            n_phase = begin_phase(seq_kind(3'd0));
                            n_shift = seq_byte(3'd0);
                        end
                    endcase
                end
            end
            PH_FINISH: begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            PH_RST_LOW: begin
                busy    = 1'b1;
                drive   = 1'b1;
                n_timer = timer_inc;
                if (timer_inc >= lim(16'(r_rst_low))) begin
                    n_phase = PH_RST_REL;
                    n_timer = '0;
                end
            end
            PH_RST_REL: begin
                busy    = 1'b1;
                n_timer = timer_inc;
                if (timer_inc >= lim(16'(r_rst_rel))) begin
                    n_phase = PH_PRES_WAIT;
                    n_timer = '0;
                end
            end
            PH_PRES_WAIT: begin
                busy = 1'b1;
                if (!i_in.dq_sample) begin
                    // The first low sample already counts toward the pulse limit.
                    n_timer = TIMER_BITS'(1);
                    if (lim(16'(r_pres_low)) <= TIMER_BITS'(1)) begin
                        n_fail = 1'b1;
                        op_end = 1'b1;
                    end else begin
                        n_phase = PH_PRES_LOW;
                    end
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= lim(16'(r_pres_wait))) begin
                        n_fail = 1'b1;
                        op_end = 1'b1;
                    end
                end
            end
            PH_PRES_LOW: begin
                busy = 1'b1;
                if (i_in.dq_sample) begin
                    n_fail = 1'b0;
                    op_end = 1'b1;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= lim(16'(r_pres_low))) begin
                        n_fail = 1'b1;
                        op_end = 1'b1;
                    end
                end
            end
            PH_WR_LOW: begin
                busy    = 1'b1;
                drive   = 1'b1;
                n_timer = timer_inc;
                len     = r_shift[0] ? lim(16'(r_wr1_low)) : lim(16'(r_slot_long));
                if (timer_inc >= len) begin
                    n_phase = PH_WR_HIGH;
                    n_timer = '0;
                end
            end
            PH_WR_HIGH: begin
                busy    = 1'b1;
                n_timer = timer_inc;
                len     = r_shift[0] ? lim(16'(r_slot_long)) : lim(16'(r_wr1_low));
                if (timer_inc >= len) begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_bits  = r_bits + 4'd1;
                    n_timer = '0;
                    if (n_bits >= 4'(BITS_PER_BYTE)) begin
                        op_end = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                busy    = 1'b1;
                drive   = 1'b1;
                n_timer = TIMER_BITS'(1);
                n_phase = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                busy = 1'b1;
                if (r_timer >= lim(16'(r_rd_sample))) begin
                    n_shift = {i_in.dq_sample, r_shift[7:1]};
                    n_bits  = r_bits + 4'd1;
                    n_phase = PH_RD_REC;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_RD_REC: begin
                busy    = 1'b1;
                n_timer = timer_inc;
                if (timer_inc >= lim(16'(r_rd_rec))) begin
                    n_timer = '0;
                    if (r_bits >= 4'(BITS_PER_BYTE)) begin
                        n_rx = r_shift;
                        if (r_func == FN_TEMP) begin
                            if (r_step == 3'(SEQ_LOW_BYTE)) begin
                                n_low = r_shift;
                            end else if (r_step == 3'(SEQ_LAST)) begin
                                n_word = {r_shift, r_low};
                            end
                        end
                        op_end = 1'b1;
                    end else begin
                        n_phase = PH_RD_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // End of a bus operation: next step of the temperature sequence or finish.
        if (op_end) begin
            if (r_func == FN_TEMP && r_step < 3'(SEQ_LAST)) begin
                n_step  = r_step + 3'd1;
                n_phase = begin_phase(seq_kind(n_step));
                n_shift = seq_byte(n_step);
                n_timer = '0;
                n_bits  = '0;
            end else begin
                n_phase = PH_FINISH;
            end
        end
    end

    // Result of this tick toward the queue.
    assign o_push       = acc;
    assign o_res.drive  = drive;
    assign o_res.busy   = busy;
    assign o_res.done   = done;
    assign o_res.fail   = n_fail;
    assign o_res.rx     = n_rx;
    assign o_res.raw    = n_word;

    // The line is pulled low only during an operation.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && drive |-> busy)
        else $error("bus driven low outside an operation");

    // The done tick is always followed by idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && done |=> r_phase == PH_IDLE)
        else $error("done tick not followed by idle");

    // The bit counter never passes one byte.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 4'(BITS_PER_BYTE))
        else $error("bit counter out of range");

endmodule

@@ rtl/core/owm_queue.sv @@
// Short queue of tick results between the sequencer and the output stage.
// Depends on owm_pkg for the result type and depth.
module owm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  owm_pkg::t_res i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output owm_pkg::t_res o_data
);
    import owm_pkg::*;

    t_res              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(do_pop);
        end
    end

    // The sequencer never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

endmodule

@@ rtl/core/owm_out.sv @@
// Back part: converts the temperature word to tenths and holds the output item.
// Depends on owm_pkg and the output channel interface in owm_if.sv.
module owm_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  owm_pkg::t_res i_q_data,
    output logic          o_q_pop,
    owm_out_if.source     o_out
);
    import owm_pkg::*;

    logic                       r_valid;
    t_res                       r_res;
    logic signed [TENTHS_W-1:0] r_tenths;

    logic                       load;
    logic signed [RAW_W:0]      ext;
    logic [RAW_W:0]             mag;
    logic [RAW_W+3:0]           mag5;
    logic [RAW_W:0]             quot;
    logic [TENTHS_W-1:0]        sat;
    logic signed [TENTHS_W-1:0] tenths;

    assign load    = i_q_valid && (!r_valid || o_out.ready);
    assign o_q_pop = load;

    // Magnitude times 5/8, truncated, saturated, sign restored.
    always_comb begin
        ext  = {i_q_data.raw[RAW_W-1], i_q_data.raw};
        mag  = i_q_data.raw[RAW_W-1] ? (RAW_W+1)'(-ext) : (RAW_W+1)'(ext);
        mag5 = {3'b000, mag} + {1'b0, mag, 2'b00};
        quot = mag5[RAW_W+3:3];
        sat  = (quot > (RAW_W+1)'(TENTHS_MAX)) ? TENTHS_W'(TENTHS_MAX) : quot[TENTHS_W-1:0];
        tenths = i_q_data.raw[RAW_W-1] ? -$signed(sat) : $signed(sat);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res    <= i_q_data;
            r_tenths <= tenths;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.dq_drive_low  = r_res.drive;
    assign o_out.busy_res      = r_res.busy;
    assign o_out.done_res      = r_res.done;
    assign o_out.presence_fail = r_res.fail;
    assign o_out.rx_byte       = r_res.rx;
    assign o_out.raw_temp      = $signed(r_res.raw);
    assign o_out.temp_tenths   = r_tenths;

endmodule

@@ rtl/core/one_wire_temp_sensor_master_top.sv @@
// 1-Wire temperature master top level: one input item per microsecond tick.
// A tick's result item passes through the queue and then the output register before it is shown.
// The block takes one tick item per cycle while the queue is not full.
// Reset (synchronous, active low): registers take defaults, queue empties,
// the sequencer goes idle with its fail flag at 1 and the output valid drops.
// Depends on owm_pkg, owm_if.sv, owm_ctrl, owm_queue and owm_out.
module one_wire_temp_sensor_master_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owm_in_if.sink     i_in,
    owm_cfg_if.sink    i_cfg,
    owm_out_if.source  o_out
);
    import owm_pkg::*;

    logic push, q_full, q_valid, q_pop;
    t_res push_res, q_res;

    // Front: sequencer.
    owm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_res    (push_res)
    );

    // Queue between the two parts.
    owm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_res),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_res)
    );

    // Back: conversion and output register.
    owm_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_res),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
